// File: rtl/mmbc_pkg.sv
`timescale 1ns / 1ps
package mmbc_pkg;

  // Frame geometry
  localparam int MAX_DIM  = 2048;
  localparam int DIM_W    = 12;
  localparam int POS_W    = 11;

  // Field widths
  localparam int PIX_W    = 8;
  localparam int PSUM_W   = 30;
  localparam int SQSUM_W  = 38;
  localparam int COUNT_W  = 21;
  localparam int LIMIT_W  = 8;
  localparam int N_W      = 23;
  localparam int LIM_SQ_W = 16;
  localparam int NN_W     = 45;
  localparam int CMP_W    = 61;
  localparam int MUL_W    = 32;

  localparam logic [PIX_W-1:0]   CHANGED   = 8'd255;
  localparam logic [DIM_W-1:0]   PAD       = 12'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X_FIRST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y_FIRST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y_END    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHANGES     = 3'd7;
  localparam int CFG_DATA_W = 21;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [POS_W-1:0]   window_x_first;
    logic [DIM_W-1:0]   window_x_end;
    logic [POS_W-1:0]   window_y_first;
    logic [DIM_W-1:0]   window_y_end;
    logic [LIMIT_W-1:0] deviation_limit;
    logic [COUNT_W-1:0] min_changes;
  } cfg_t;

  // Statistics of one finished frame, passed from front to back
  typedef struct packed {
    logic [PSUM_W-1:0]  pixel_sum;
    logic [SQSUM_W-1:0] square_sum;
    logic [COUNT_W-1:0] changed_total;
    logic [DIM_W-1:0]   least_column;
    logic [POS_W-1:0]   greatest_column;
    logic [DIM_W-1:0]   least_row;
    logic [POS_W-1:0]   greatest_row;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } job_t;

  typedef struct packed {
    logic [COUNT_W-1:0] change_count;
    logic               deviation_ok;
    logic               box_valid;
    logic [DIM_W-1:0]   box_left;
    logic [DIM_W-1:0]   box_top;
    logic [POS_W-1:0]   box_right;
    logic [POS_W-1:0]   box_bottom;
    logic               motion_seen;
  } result_t;

  // Clamp a frame dimension to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/mmbc_if.sv
`timescale 1ns / 1ps
interface mmbc_in_if import mmbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface mmbc_out_if import mmbc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] change_count;
  logic               deviation_ok;
  logic               box_valid;
  logic [DIM_W-1:0]   box_left;
  logic [DIM_W-1:0]   box_top;
  logic [POS_W-1:0]   box_right;
  logic [POS_W-1:0]   box_bottom;
  logic               motion_seen;

  modport source (output valid, change_count, deviation_ok, box_valid, box_left, box_top,
                  box_right, box_bottom, motion_seen, input ready);
  modport sink   (input valid, change_count, deviation_ok, box_valid, box_left, box_top,
                  box_right, box_bottom, motion_seen, output ready);
endinterface

// File: rtl/mmbc_front.sv
`timescale 1ns / 1ps
module mmbc_front import mmbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  mmbc_in_if.sink     in_word,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [POS_W-1:0]   col_r, col_nxt;
  logic [POS_W-1:0]   row_r, row_nxt;
  logic [PSUM_W-1:0]  psum_r, psum_nxt;
  logic [SQSUM_W-1:0] sq_r, sq_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic [DIM_W-1:0]   lc_r, lc_nxt;
  logic [POS_W-1:0]   gc_r, gc_nxt;
  logic [DIM_W-1:0]   lr_r, lr_nxt;
  logic [POS_W-1:0]   gr_r, gr_nxt;

  logic [DIM_W-1:0]   w_eff, h_eff;
  logic               accept, fs;
  logic [POS_W-1:0]   col, row;
  logic [PSUM_W-1:0]  psum_upd;
  logic [SQSUM_W-1:0] sq_upd;
  logic [COUNT_W-1:0] total_cur, total_upd;
  logic [DIM_W-1:0]   lc_cur, lc_upd, lr_cur, lr_upd;
  logic [POS_W-1:0]   gc_cur, gc_upd, gr_cur, gr_upd;
  logic [15:0]        px_sq;
  logic               x_hit, y_hit, hit;
  logic               last_col, last_row;

  assign w_eff  = clamp_dim(cfg.frame_width);
  assign h_eff  = clamp_dim(cfg.frame_height);
  assign in_word.ready = !q_full;
  assign accept = in_word.valid && !q_full;
  assign fs     = in_word.frame_start;

  // Start of frame: drop whatever the previous partial frame left
  assign col       = fs ? '0 : col_r;
  assign row       = fs ? '0 : row_r;
  assign total_cur = fs ? '0 : total_r;
  assign lc_cur    = fs ? w_eff : lc_r;
  assign gc_cur    = fs ? '0 : gc_r;
  assign lr_cur    = fs ? h_eff : lr_r;
  assign gr_cur    = fs ? '0 : gr_r;

  // Accumulate sum and sum of squares, both wrapping
  assign px_sq    = in_word.pixel * in_word.pixel;
  assign psum_upd = (fs ? '0 : psum_r) + PSUM_W'(in_word.pixel);
  assign sq_upd   = (fs ? '0 : sq_r) + SQSUM_W'(px_sq);

  // Sample every second column and row inside the window
  assign x_hit = (col >= cfg.window_x_first) && ({1'b0, col} < cfg.window_x_end) &&
                 (col[0] == cfg.window_x_first[0]);
  assign y_hit = (row >= cfg.window_y_first) && ({1'b0, row} < cfg.window_y_end) &&
                 (row[0] == cfg.window_y_first[0]);
  assign hit   = (in_word.pixel == CHANGED) && x_hit && y_hit;

  // Count with saturation and grow the box
  assign total_upd = (hit && total_cur != COUNT_MAX) ? total_cur + COUNT_W'(1) : total_cur;
  assign lc_upd    = (hit && {1'b0, col} < lc_cur) ? {1'b0, col} : lc_cur;
  assign gc_upd    = (hit && col > gc_cur) ? col : gc_cur;
  assign lr_upd    = (hit && {1'b0, row} < lr_cur) ? {1'b0, row} : lr_cur;
  assign gr_upd    = (hit && row > gr_cur) ? row : gr_cur;

  assign last_col = ({1'b0, col} + DIM_W'(1)) >= w_eff;
  assign last_row = ({1'b0, row} + DIM_W'(1)) >= h_eff;

  // Hand the finished frame to the back end
  assign q_push = accept && last_col && last_row;
  always_comb begin
    q_job.pixel_sum       = psum_upd;
    q_job.square_sum      = sq_upd;
    q_job.changed_total   = total_upd;
    q_job.least_column    = lc_upd;
    q_job.greatest_column = gc_upd;
    q_job.least_row       = lr_upd;
    q_job.greatest_row    = gr_upd;
    q_job.width           = w_eff;
    q_job.height          = h_eff;
  end

  // Advance the raster position, clear at end of frame
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    psum_nxt  = psum_r;
    sq_nxt    = sq_r;
    total_nxt = total_r;
    lc_nxt    = lc_r;
    gc_nxt    = gc_r;
    lr_nxt    = lr_r;
    gr_nxt    = gr_r;
    if (accept) begin
      if (last_col && last_row) begin
        col_nxt   = '0;
        row_nxt   = '0;
        psum_nxt  = '0;
        sq_nxt    = '0;
        total_nxt = '0;
        lc_nxt    = w_eff;
        gc_nxt    = '0;
        lr_nxt    = h_eff;
        gr_nxt    = '0;
      end else begin
        col_nxt   = last_col ? '0 : col + POS_W'(1);
        row_nxt   = last_col ? row + POS_W'(1) : row;
        psum_nxt  = psum_upd;
        sq_nxt    = sq_upd;
        total_nxt = total_upd;
        lc_nxt    = lc_upd;
        gc_nxt    = gc_upd;
        lr_nxt    = lr_upd;
        gr_nxt    = gr_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      psum_r  <= '0;
      sq_r    <= '0;
      total_r <= '0;
      lc_r    <= DIM_W'(640);
      gc_r    <= '0;
      lr_r    <= DIM_W'(480);
      gr_r    <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      psum_r  <= psum_nxt;
      sq_r    <= sq_nxt;
      total_r <= total_nxt;
      lc_r    <= lc_nxt;
      gc_r    <= gc_nxt;
      lr_r    <= lr_nxt;
      gr_r    <= gr_nxt;
    end
  end

endmodule

// File: rtl/mmbc_queue.sv
`timescale 1ns / 1ps
module mmbc_queue import mmbc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  job_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_job = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  // Hold frame records
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/mmbc_back.sv
`timescale 1ns / 1ps
module mmbc_back import mmbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  job_t        q_job,
  output logic        q_pop,
  mmbc_out_if.source  out_word
);

  // Sequencer steps: each of S_WH to S_LNN_HI issues one product, the next step folds it in
  localparam logic [3:0] S_WH     = 4'd0;
  localparam logic [3:0] S_LL     = 4'd1;
  localparam logic [3:0] S_NN     = 4'd2;
  localparam logic [3:0] S_NSQ_LO = 4'd3;
  localparam logic [3:0] S_NSQ_HI = 4'd4;
  localparam logic [3:0] S_PSQ    = 4'd5;
  localparam logic [3:0] S_LNN_LO = 4'd6;
  localparam logic [3:0] S_LNN_HI = 4'd7;
  localparam logic [3:0] S_FOLD   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic                busy_r, busy_nxt;
  logic [3:0]          step_r, step_nxt;
  job_t                job_r;
  logic [2*MUL_W-1:0]  prod_r;
  logic [N_W-1:0]      n_r;
  logic [LIM_SQ_W-1:0] lim_r;
  logic [NN_W-1:0]     nn_r;
  logic [CMP_W-1:0]    lhs_r, rhs_r;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_r;

  logic [MUL_W-1:0]    op_a, op_b;
  logic                finish;
  logic                ok, box_ok;
  logic [COUNT_W-1:0]  count;
  result_t             res;
  logic [DIM_W-1:0]    right_pad, bottom_pad;

  assign q_pop  = !busy_r && !q_empty;
  assign finish = busy_r && (step_r == S_DONE) && (!out_valid_r || out_word.ready);

  // Select multiplier operands for this step
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_r)
      S_WH: begin
        op_a = MUL_W'(job_r.width);
        op_b = MUL_W'(job_r.height);
      end
      S_LL: begin
        op_a = MUL_W'(cfg.deviation_limit);
        op_b = MUL_W'(cfg.deviation_limit);
      end
      S_NN: begin
        op_a = MUL_W'(n_r);
        op_b = MUL_W'(n_r);
      end
      S_NSQ_LO: begin
        op_a = MUL_W'(n_r);
        op_b = job_r.square_sum[31:0];
      end
      S_NSQ_HI: begin
        op_a = MUL_W'(n_r);
        op_b = MUL_W'(job_r.square_sum[SQSUM_W-1:32]);
      end
      S_PSQ: begin
        op_a = MUL_W'(job_r.pixel_sum);
        op_b = MUL_W'(job_r.pixel_sum);
      end
      S_LNN_LO: begin
        op_a = MUL_W'(lim_r);
        op_b = nn_r[31:0];
      end
      S_LNN_HI: begin
        op_a = MUL_W'(lim_r);
        op_b = MUL_W'(nn_r[NN_W-1:32]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Multiply and fold the previous product
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (busy_r) begin
      unique case (step_r)
        S_LL:     n_r   <= prod_r[N_W-1:0];
        S_NN:     lim_r <= prod_r[LIM_SQ_W-1:0];
        S_NSQ_LO: nn_r  <= prod_r[NN_W-1:0];
        S_NSQ_HI: lhs_r <= prod_r[CMP_W-1:0];
        S_PSQ:    lhs_r <= lhs_r + {prod_r[CMP_W-33:0], 32'd0};
        S_LNN_LO: rhs_r <= prod_r[CMP_W-1:0];
        S_LNN_HI: rhs_r <= rhs_r + prod_r[CMP_W-1:0];
        S_FOLD:   rhs_r <= rhs_r + {prod_r[CMP_W-33:0], 32'd0};
        default: begin
        end
      endcase
    end
  end

  // Gate the count and pad the box
  always_comb begin
    ok         = lhs_r < rhs_r;
    count      = ok ? job_r.changed_total : '0;
    box_ok     = ok && (count != '0);
    right_pad  = {1'b0, job_r.greatest_column} + PAD;
    bottom_pad = {1'b0, job_r.greatest_row} + PAD;
    res.change_count = count;
    res.deviation_ok = ok;
    res.box_valid    = box_ok;
    res.motion_seen  = count >= cfg.min_changes;
    res.box_left     = '0;
    res.box_top      = '0;
    res.box_right    = '0;
    res.box_bottom   = '0;
    if (box_ok) begin
      res.box_left   = (job_r.least_column > PAD) ? job_r.least_column - PAD
                                                  : job_r.least_column;
      res.box_top    = (job_r.least_row > PAD) ? job_r.least_row - PAD : job_r.least_row;
      res.box_right  = (right_pad < job_r.width - DIM_W'(1)) ? right_pad[POS_W-1:0]
                                                             : job_r.greatest_column;
      res.box_bottom = (bottom_pad < job_r.height - DIM_W'(1)) ? bottom_pad[POS_W-1:0]
                                                               : job_r.greatest_row;
    end
  end

  // Load a new frame record when free
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      step_nxt = S_WH;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end else if (busy_r && step_r != S_DONE) begin
      step_nxt = step_r + 4'd1;
    end
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= S_WH;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_r <= res;
    end
  end

  // Drive the result word
  assign out_word.valid        = out_valid_r;
  assign out_word.change_count = out_r.change_count;
  assign out_word.deviation_ok = out_r.deviation_ok;
  assign out_word.box_valid    = out_r.box_valid;
  assign out_word.box_left     = out_r.box_left;
  assign out_word.box_top      = out_r.box_top;
  assign out_word.box_right    = out_r.box_right;
  assign out_word.box_bottom   = out_r.box_bottom;
  assign out_word.motion_seen  = out_r.motion_seen;

endmodule

// File: rtl/motion_mask_box_counter.sv
`timescale 1ns / 1ps
// Motion-mask box counter.
// in_word carries one mask pixel per word in raster order, with frame_start
// high on the first pixel of a frame. The block keeps the frame's pixel sum
// and sum of squares, counts changed pixels (value 255) on every second row
// and column of the detection window and tracks their bounding box.
// For each frame one word leaves on out_word: the gated count,
// the deviation flag, the padded box and the motion flag.
// Pixels are taken at one per clock while the queue is not full. A finished
// frame's statistics enter a two-entry queue; the back end evaluates the
// deviation gate with one shared 32x32 multiplier over ten steps and takes
// a new frame record only when it is idle, so short frames can fill the
// queue, and in_word.ready falls while the queue is full.
// The output register holds a result until out_word.ready; the back end and
// then the queue fill behind it; in_word.ready falls once the queue is full.
// Registers must be written through cfg_we/cfg_index/cfg_data only while no
// result is pending (the block does not enforce it); new frame sizes apply at once.
// Reset (rst_n low, synchronous) restores the register defaults, empties the
// queue and starts a new frame at column 0, row 0.
module motion_mask_box_counter import mmbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mmbc_in_if.sink               in_word,
  mmbc_out_if.source            out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  logic q_push, q_pop, q_full, q_empty;
  job_t push_job, pop_job;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width     <= DIM_W'(640);
      cfg_r.frame_height    <= DIM_W'(480);
      cfg_r.window_x_first  <= POS_W'(1);
      cfg_r.window_x_end    <= DIM_W'(639);
      cfg_r.window_y_first  <= POS_W'(1);
      cfg_r.window_y_end    <= DIM_W'(479);
      cfg_r.deviation_limit <= LIMIT_W'(50);
      cfg_r.min_changes     <= COUNT_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:     cfg_r.frame_width     <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:    cfg_r.frame_height    <= cfg_data[DIM_W-1:0];
        REG_WINDOW_X_FIRST:  cfg_r.window_x_first  <= cfg_data[POS_W-1:0];
        REG_WINDOW_X_END:    cfg_r.window_x_end    <= cfg_data[DIM_W-1:0];
        REG_WINDOW_Y_FIRST:  cfg_r.window_y_first  <= cfg_data[POS_W-1:0];
        REG_WINDOW_Y_END:    cfg_r.window_y_end    <= cfg_data[DIM_W-1:0];
        REG_DEVIATION_LIMIT: cfg_r.deviation_limit <= cfg_data[LIMIT_W-1:0];
        REG_MIN_CHANGES:     cfg_r.min_changes     <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mmbc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_word (in_word),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  mmbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  mmbc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_job    (pop_job),
    .q_pop    (q_pop),
    .out_word (out_word)
  );

endmodule
